// File: sv/msec_pkg.sv
// Package for the min_step_equalize_cost block: payload structs, queue entry,
// back-end state encoding and sizing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msec_pkg;

    localparam int MSEC_VAL_W       = 16;
    localparam int MSEC_MOVES_W     = 26;
    localparam int MSEC_MAX_ITEMS   = 1024;
    localparam int MSEC_QUEUE_DEPTH = 2;
    localparam logic [MSEC_VAL_W-1:0] MSEC_STEP_RESET = 16'd1;

    typedef struct packed {
        logic [MSEC_VAL_W-1:0] sample_value;
        logic                  last_item;
    } t_item;

    typedef struct packed {
        logic                    feasible;
        logic [MSEC_MOVES_W-1:0] total_moves;
    } t_res;

    // One queue entry: the value, whether the store takes it, whether it closes the set.
    typedef struct packed {
        logic [MSEC_VAL_W-1:0] value;
        logic                  keep;
        logic                  last;
    } t_cmd;

    typedef enum logic [3:0] {
        BK_LOAD,
        BK_BASE,
        BK_BASE_CAP,
        BK_CHK_RD,
        BK_CHK_DIV,
        BK_CHK_WAIT,
        BK_ROW_RD,
        BK_ROW_CAP,
        BK_SWEEP,
        BK_ROW_END,
        BK_DIV_START,
        BK_DIV_WAIT,
        BK_OUT
    } t_bk_state;

endpackage

`default_nettype wire

// File: sv/msec_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msec_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: sv/msec_fifo.sv
// Short queue of t_cmd entries between the front end and the back end.
// Depends on msec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msec_fifo
    import msec_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    localparam int QD  = MSEC_QUEUE_DEPTH;
    localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW = $clog2(QD + 1);

    t_cmd             r_mem [QD];
    logic [QAW-1:0]   r_wp, n_wp;
    logic [QAW-1:0]   r_rp, n_rp;
    logic [QCW-1:0]   r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == QCW'(QD));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == QAW'(QD - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == QAW'(QD - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: sv/msec_front.sv
// Front end: accepts input beats, tags each as kept or dropped by store fill,
// and pushes it into the queue. Depends on msec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msec_front
    import msec_pkg::*;
#(
    parameter int MAX_ITEMS = MSEC_MAX_ITEMS,
    localparam int CNT_W = $clog2(MAX_ITEMS + 1)
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire t_item i_item,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  wire logic  i_q_full
);

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             keep;

    assign keep       = (r_cnt < CNT_W'(MAX_ITEMS));
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_cmd      = '{value: i_item.sample_value, keep: keep, last: i_item.last_item};

    always_comb begin
        n_cnt = r_cnt;
        if (o_push) begin
            if (i_item.last_item) begin
                n_cnt = '0;
            end else if (keep) begin
                n_cnt = r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

// File: sv/msec_div.sv
// Restoring divider, one quotient bit per cycle, 16-bit divisor.
// No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module msec_div #(
    parameter int W = 27,
    localparam int CW = $clog2(W)
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_dividend,
    input  wire logic [15:0]  i_divisor,
    output logic              o_done,
    output logic [W-1:0]      o_quotient,
    output logic [15:0]       o_remainder
);

    logic [W-1:0]  r_quo;
    logic [15:0]   r_rem;
    logic [15:0]   r_dvs;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [16:0]   trial;
    logic          fits;

    assign trial = {r_rem, r_quo[W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? 16'(trial - {1'b0, r_dvs}) : trial[15:0];
            r_quo <= {r_quo[W-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

`default_nettype wire

// File: sv/msec_back.sv
// Back end: writes queued values into the store, then on a closing entry runs
// the residue check, the all-targets cost sweep and the final divide.
// Depends on msec_pkg, msec_ram and msec_div.
`timescale 1ns / 1ps
`default_nettype none

module msec_back
    import msec_pkg::*;
#(
    parameter int MAX_ITEMS = MSEC_MAX_ITEMS,
    localparam int CNT_W = $clog2(MAX_ITEMS + 1),
    localparam int AW    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1,
    localparam int SUM_W = CNT_W + MSEC_VAL_W,
    localparam int QX_W  = (SUM_W > MSEC_MOVES_W) ? SUM_W : MSEC_MOVES_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [MSEC_VAL_W-1:0] i_cfg_wdata,
    input  wire logic                  i_q_valid,
    input  wire t_cmd                  i_q_cmd,
    output logic                       o_q_pop,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_res                       o_res
);

    function automatic logic [MSEC_VAL_W-1:0] absdiff(
        input logic [MSEC_VAL_W-1:0] a,
        input logic [MSEC_VAL_W-1:0] b
    );
        absdiff = (a >= b) ? a - b : b - a;
    endfunction

    t_bk_state              r_state, n_state;
    logic [MSEC_VAL_W-1:0]  r_step;
    logic [CNT_W-1:0]       r_wcnt, n_wcnt;
    logic [CNT_W-1:0]       r_n, n_n;
    logic [CNT_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_tgt, n_tgt;
    logic [CNT_W-1:0]       r_j, n_j;
    logic                   r_pend, n_pend;
    logic [MSEC_VAL_W-1:0]  r_base, n_base;
    logic [MSEC_VAL_W-1:0]  r_tv, n_tv;
    logic [SUM_W-1:0]       r_sum, n_sum;
    logic [SUM_W-1:0]       r_best, n_best;
    t_res                   r_res, n_res;
    logic                   r_out_vld, n_out_vld;
    t_res                   r_out, n_out;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [AW-1:0]          ram_raddr;
    logic [MSEC_VAL_W-1:0]  ram_rdata;
    logic                   div_start;
    logic [SUM_W-1:0]       div_dividend;
    logic                   div_done;
    logic [SUM_W-1:0]       div_quo;
    logic [15:0]            div_rem;
    logic [15:0]            divisor;
    logic [QX_W-1:0]        quo_x;
    logic [MSEC_MOVES_W-1:0] moves_sat;

    assign divisor   = (r_step == '0) ? 16'd1 : r_step;
    assign quo_x     = QX_W'(div_quo);
    assign moves_sat = (quo_x > QX_W'({MSEC_MOVES_W{1'b1}})) ? '1 : MSEC_MOVES_W'(quo_x);
    assign ram_waddr = r_wcnt[AW-1:0];

    msec_ram #(
        .WIDTH (MSEC_VAL_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_q_cmd.value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    msec_div #(
        .W (SUM_W)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        n_state      = r_state;
        n_wcnt       = r_wcnt;
        n_n          = r_n;
        n_idx        = r_idx;
        n_tgt        = r_tgt;
        n_j          = r_j;
        n_pend       = 1'b0;
        n_base       = r_base;
        n_tv         = r_tv;
        n_sum        = r_sum;
        n_best       = r_best;
        n_res        = r_res;
        n_out        = r_out;
        n_out_vld    = r_out_vld && i_out_stall;
        o_q_pop      = 1'b0;
        ram_we       = 1'b0;
        ram_raddr    = '0;
        div_start    = 1'b0;
        div_dividend = r_best;

        unique case (r_state)
            BK_LOAD: begin
                o_q_pop = i_q_valid;
                if (i_q_valid) begin
                    ram_we = i_q_cmd.keep;
                    if (i_q_cmd.keep) begin
                        n_wcnt = r_wcnt + 1'b1;
                    end
                    if (i_q_cmd.last) begin
                        n_n     = r_wcnt + CNT_W'(i_q_cmd.keep);
                        n_wcnt  = '0;
                        n_state = BK_BASE;
                    end
                end
            end
            BK_BASE: begin
                ram_raddr = '0;
                n_state   = BK_BASE_CAP;
            end
            BK_BASE_CAP: begin
                n_base  = ram_rdata;
                n_idx   = CNT_W'(1);
                n_state = BK_CHK_RD;
            end
            BK_CHK_RD: begin
                ram_raddr = r_idx[AW-1:0];
                if (r_idx == r_n) begin
                    n_tgt   = '0;
                    n_state = BK_ROW_RD;
                end else begin
                    n_state = BK_CHK_DIV;
                end
            end
            BK_CHK_DIV: begin
                div_start    = 1'b1;
                div_dividend = SUM_W'(absdiff(ram_rdata, r_base));
                n_state      = BK_CHK_WAIT;
            end
            BK_CHK_WAIT: begin
                if (div_done) begin
                    if (div_rem != '0) begin
                        n_res   = '{feasible: 1'b0, total_moves: '0};
                        n_state = BK_OUT;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = BK_CHK_RD;
                    end
                end
            end
            BK_ROW_RD: begin
                ram_raddr = r_tgt[AW-1:0];
                n_state   = BK_ROW_CAP;
            end
            BK_ROW_CAP: begin
                n_tv    = ram_rdata;
                n_j     = '0;
                n_sum   = '0;
                n_state = BK_SWEEP;
            end
            BK_SWEEP: begin
                // Issue one read a cycle, add the previous read's distance.
                if (r_j != r_n) begin
                    ram_raddr = r_j[AW-1:0];
                    n_j       = r_j + 1'b1;
                    n_pend    = 1'b1;
                end
                if (r_pend) begin
                    n_sum = r_sum + SUM_W'(absdiff(ram_rdata, r_tv));
                end
                if (r_j == r_n && !r_pend) begin
                    n_state = BK_ROW_END;
                end
            end
            BK_ROW_END: begin
                if (r_tgt == '0 || r_sum < r_best) begin
                    n_best = r_sum;
                end
                if (r_tgt == r_n - 1'b1) begin
                    n_state = BK_DIV_START;
                end else begin
                    n_tgt   = r_tgt + 1'b1;
                    n_state = BK_ROW_RD;
                end
            end
            BK_DIV_START: begin
                div_start    = 1'b1;
                div_dividend = r_best;
                n_state      = BK_DIV_WAIT;
            end
            BK_DIV_WAIT: begin
                if (div_done) begin
                    n_res   = '{feasible: 1'b1, total_moves: moves_sat};
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                // Hand over once the output register is empty or being drained.
                if (!r_out_vld || !i_out_stall) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = BK_LOAD;
                end
            end
            default: begin
                n_state = BK_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_LOAD;
            r_step    <= MSEC_STEP_RESET;
            r_wcnt    <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            r_wcnt    <= n_wcnt;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n    <= n_n;
        r_idx  <= n_idx;
        r_tgt  <= n_tgt;
        r_j    <= n_j;
        r_base <= n_base;
        r_tv   <= n_tv;
        r_sum  <= n_sum;
        r_best <= n_best;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_vld;
    assign o_res       = r_out;

endmodule

`default_nettype wire

// File: sv/min_step_equalize_cost.sv
// Top level of min_step_equalize_cost: front end, queue and back end.
// Depends on msec_pkg, msec_front, msec_fifo and msec_back.
//
// Values stream in at one beat per cycle and are stored until a beat with
// last_item set closes the set; beats past MAX_ITEMS are dropped, a closing
// beat still closes. For a set of n values the back end then runs the residue
// check (one serial divide of W = clog2(MAX_ITEMS+1)+16 bits per value after
// the first, stopping early on a mismatch), the cost sweep (one store read
// port, one value a cycle) and the final divide by the step, then posts one
// result. Input stalls once the two-entry queue fills during that phase. A
// step of zero acts as one; total_moves saturates at 2^26-1. Write step_size
// only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module min_step_equalize_cost
    import msec_pkg::*;
#(
    parameter int MAX_ITEMS = MSEC_MAX_ITEMS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_item                 i_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_res                       o_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [MSEC_VAL_W-1:0] i_cfg_wdata
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    msec_front #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_item     (i_item),
        .o_push     (q_push),
        .o_cmd      (push_cmd),
        .i_q_full   (q_full)
    );

    msec_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    msec_back #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire

// File: verif/msec_moves_checker.sv
// Checker for min_step_equalize_cost: watches the item, result and step ports,
// predicts each set's move count and compares results in order. Depends on msec_pkg.
`timescale 1ns / 1ps

module msec_moves_checker
    import msec_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  t_item                      i_item,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  t_res                       i_res,
    input  wire logic                  i_cfg_we,
    input  wire logic [MSEC_VAL_W-1:0] i_cfg_wdata,
    output int                         o_fail_count,
    output int                         o_pending
);

    localparam longint unsigned MOVES_CAP = (64'd1 << MSEC_MOVES_W) - 64'd1;

    logic [MSEC_VAL_W-1:0] step_reg;
    logic [MSEC_VAL_W-1:0] set_vals [MSEC_MAX_ITEMS];
    int                    set_len;
    t_res                  moves_due [$];

    function automatic t_res predict_moves();
        t_res            r;
        int unsigned     d;
        int unsigned     base;
        int unsigned     diff;
        longint unsigned sum;
        longint unsigned best;
        bit              ok;
        // a zero step moves like a step of one
        d    = (step_reg == '0) ? 1 : step_reg;
        base = (set_len > 0) ? set_vals[0] % d : 0;
        ok   = 1'b1;
        for (int i = 0; i < set_len && ok; i++)
            if (set_vals[i] % d != base) ok = 1'b0;
        r = '0;
        if (ok) begin
            best = '1;
            for (int t = 0; t < set_len; t++) begin
                sum = 0;
                for (int j = 0; j < set_len; j++) begin
                    diff = (set_vals[t] >= set_vals[j]) ? set_vals[t] - set_vals[j]
                                                        : set_vals[j] - set_vals[t];
                    sum += diff / d;
                end
                if (sum < best) best = sum;
            end
            if (best > MOVES_CAP) best = MOVES_CAP;
            r.feasible    = 1'b1;
            r.total_moves = best[MSEC_MOVES_W-1:0];
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            step_reg     = MSEC_STEP_RESET;
            set_len      = 0;
            o_fail_count = 0;
            moves_due.delete();
        end else begin
            if (i_cfg_we) step_reg = i_cfg_wdata;
            if (i_in_valid && !i_in_stall) begin
                // drop values once the store is full; a closing beat still closes
                if (set_len < MSEC_MAX_ITEMS) begin
                    set_vals[set_len] = i_item.sample_value;
                    set_len++;
                end
                if (i_item.last_item) begin
                    moves_due.insert(moves_due.size(), predict_moves());
                    set_len = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (moves_due.size() == 0) begin
                    $error("unexpected result beat: feasible %0d total_moves %0d",
                           i_res.feasible, i_res.total_moves);
                    o_fail_count++;
                end else begin
                    want = moves_due.pop_front();
                    if (i_res.feasible !== want.feasible) begin
                        $error("feasible mismatch: expected %0d, got %0d",
                               want.feasible, i_res.feasible);
                        o_fail_count++;
                    end
                    if (i_res.total_moves !== want.total_moves) begin
                        $error("total_moves mismatch: expected %0d, got %0d",
                               want.total_moves, i_res.total_moves);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = moves_due.size();
    end

endmodule

// File: verif/tb_min_step_equalize_cost.sv
// Testbench top for min_step_equalize_cost: drives value sets and step writes,
// paces the result side and reports the verdict. Depends on msec_pkg, msec_moves_checker.
`timescale 1ns / 1ps

module tb_min_step_equalize_cost;
    import msec_pkg::*;

    localparam int RANDOM_ITEMS = 650;
    localparam int LONG_HOLD    = 8000;
    localparam int SETTLE       = 8;
    localparam int DRAIN        = 200;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    t_item                 item;
    logic                  out_valid;
    logic                  out_stall;
    t_res                  res;
    logic                  cfg_we;
    logic [MSEC_VAL_W-1:0] cfg_wdata;

    int fail_count;
    int pending;
    bit calm;
    int hold_asked;
    int hold_done;
    int random_sent;

    min_step_equalize_cost dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_item      (item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    msec_moves_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_item       (item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_res        (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("FAIL min_step_equalize_cost");
        $finish;
    end

    // Enter and leave at a falling edge; valid stays high when the next beat follows at once.
    task automatic send_beat(input logic [MSEC_VAL_W-1:0] v, input logic closes);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid               <= 1'b1;
        item.sample_value      <= v;
        item.last_item         <= closes;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Wait for the block to go idle, then write the step.
    task automatic write_step(input logic [MSEC_VAL_W-1:0] v);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Result side: random stalls per beat, plus one long hold on request.
    initial begin
        int gap;
        out_stall = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever begin
            if (hold_asked != hold_done) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                hold_done++;
            end
            gap = calm ? 0 : $urandom_range(0, 6);
            out_stall <= (gap != 0);
            do @(posedge clk); while (!out_valid && hold_asked == hold_done);
            if (out_valid && gap != 0) begin
                if (gap > 1) repeat (gap - 1) @(posedge clk);
                @(negedge clk);
                out_stall <= 1'b0;
                // stalled beat holds, so it goes at the next edge
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    initial begin
        logic [MSEC_VAL_W-1:0] vals [$];
        logic [MSEC_VAL_W-1:0] step;
        logic [MSEC_VAL_W-1:0] even_val;
        int unsigned           d;
        int unsigned           base;
        int unsigned           span;
        int                    len;
        int                    kind;
        int                    phase;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        item        = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        calm        = 1'b0;
        hold_asked  = 0;
        hold_done   = 0;
        random_sent = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // step at its reset value: widest spread, lone value, ties
        send_beat(16'd0, 1'b0);
        send_beat(16'hFFFF, 1'b1);
        send_beat(16'd42, 1'b1);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'd0, 1'b0);
        send_beat(16'hFFFF, 1'b1);

        // zero step acts as one
        write_step(16'd0);
        send_beat(16'd5, 1'b0);
        send_beat(16'd7, 1'b0);
        send_beat(16'd9, 1'b0);
        send_beat(16'd4, 1'b1);

        write_step(16'hFFFF);
        send_beat(16'd0, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'hFFFF, 1'b0);
        send_beat(16'd0, 1'b0);
        send_beat(16'hFFFF, 1'b1);

        // mixed parity is infeasible, then a feasible even set
        write_step(16'd2);
        send_beat(16'd1, 1'b0);
        send_beat(16'd2, 1'b1);
        send_beat(16'd2, 1'b0);
        send_beat(16'd4, 1'b0);
        send_beat(16'd10, 1'b1);

        write_step(16'd3);
        send_beat(16'd3, 1'b0);
        send_beat(16'd9, 1'b0);
        send_beat(16'd12, 1'b0);
        send_beat(16'd30, 1'b1);

        phase = 0;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 6))
                0:       step = 16'd1;
                1:       step = 16'hFFFF;
                2:       step = 16'd0;
                3:       step = 16'd2;
                4:       step = MSEC_VAL_W'($urandom_range(3, 16));
                5:       step = MSEC_VAL_W'($urandom_range(17, 300));
                default: step = MSEC_VAL_W'($urandom_range(1, 65535));
            endcase
            write_step(step);
            calm = ($urandom_range(0, 3) == 0);
            // first phase: hold results long enough for the input to back up
            if (phase == 0) hold_asked++;
            d = (step == '0) ? 1 : step;
            repeat ($urandom_range(6, 12)) begin
                len  = ($urandom_range(0, 11) == 0) ? $urandom_range(13, 48)
                                                    : $urandom_range(1, 12);
                kind = $urandom_range(0, 99);
                base = $urandom_range(0, d - 1);
                span = $urandom_range(0, (65535 - base) / d);
                vals.delete();
                for (int i = 0; i < len; i++)
                    vals.insert(vals.size(),
                                MSEC_VAL_W'((kind < 80) ? base + d * $urandom_range(0, span)
                                                        : $urandom_range(0, 65535)));
                // corrupt one value of an otherwise aligned set
                if (kind >= 60 && kind < 80)
                    vals[$urandom_range(0, len - 1)] = MSEC_VAL_W'($urandom_range(0, 65535));
                foreach (vals[i]) send_beat(vals[i], i == vals.size() - 1);
                random_sent += len;
            end
            phase++;
        end

        // overfill the store: the one odd value sits in the last slot,
        // the beats after it are dropped and the final one still closes
        write_step(16'd2);
        calm = 1'b1;
        for (int i = 0; i < MSEC_MAX_ITEMS + 2; i++) begin
            even_val = MSEC_VAL_W'($urandom_range(0, 32767) * 2);
            send_beat((i == MSEC_MAX_ITEMS - 1) ? (even_val | 16'd1) : even_val,
                      i == MSEC_MAX_ITEMS + 1);
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN) @(negedge clk);
        if (pending != 0)
            $error("%0d expected results never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS min_step_equalize_cost");
        end else begin
            $display("FAIL min_step_equalize_cost");
        end
        $finish;
    end

endmodule
